>>> rtl/pts_pkg.sv
// Shared types and constants for the preemption-threshold scheduler.
`default_nettype none
package pts_pkg;

  localparam int unsigned PRIO_W = 6;

  typedef enum logic [2:0] {
    OP_MARK_READY     = 3'd0,
    OP_LOCK           = 3'd1,
    OP_UNLOCK         = 3'd2,
    OP_SCHEDULE       = 3'd3,
    OP_AFTER_DISPATCH = 3'd4,
    OP_SET_ACTIVE     = 3'd5
  } op_t;

  typedef struct packed {
    logic              queue_empty;
    logic              prev_not_locked;
    logic [PRIO_W-1:0] level;
    logic [PRIO_W-1:0] task_prio;
    logic [2:0]        opcode;
  } item_t;

  typedef struct packed {
    logic              error;
    logic              not_locked;
    logic [PRIO_W-1:0] ceil_before;
    logic [PRIO_W-1:0] run_prio;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/preemption_threshold_scheduler_top.sv
// Top level: stream ports, input and result registers around the scheduler core.
//
//  channel   dir  tdata fields (low bit up)                                   width
//  s_axis    in   opcode[2:0] task_prio[8:3] level[14:9] prev_not_locked[15]   24
//                 queue_empty[16], zero fill
//  m_axis    out  run_prio[5:0] ceil_before[11:6] not_locked[12] error[13]    16
//                 zero fill
//
// One operation per cycle while m_axis is not stalled: an accepted transfer is
// held in the input register, is evaluated by the core against the current state,
// and lands in the result register; state and result update on the same edge.
// m_axis_tvalid rises when the item moves into the result register, so a result
// passes through the input register and the result register before its transfer.
// rst (synchronous) empties both registers and restores the scheduler state.
// A stalled m_axis holds the result and, once the input register is full,
// drops s_axis_tready.
`default_nettype none
module preemption_threshold_scheduler_top
  import pts_pkg::*;
#(
  parameter int unsigned NUM_PRIOS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // opcode, task_prio, level, prev_not_locked,
                                          // queue_empty
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata   // run_prio, ceil_before, not_locked, error
);

  item_t   in_item;
  logic    in_valid;
  result_t out_res;
  result_t core_res;
  logic    advance;

  // the input register moves to the result register when that one frees up
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_item <= item_t'(s_axis_tdata[16:0]);
    if (advance) out_res <= core_res;
  end

  pts_core #(
    .NUM_PRIOS(NUM_PRIOS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_item),
    .res  (core_res)
  );

  assign m_axis_tdata = {2'b00, out_res};

endmodule
`default_nettype wire

>>> rtl/pts_core.sv
// Scheduler state (ready bitmap, ceiling, threshold) and per-operation logic.
`default_nettype none
module pts_core
  import pts_pkg::*;
#(
  parameter int unsigned NUM_PRIOS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire item_t   item,
  output result_t      res
);

  // ceiling must hold NUM_PRIOS + 1 as well as any 6-bit level
  localparam int unsigned CEIL_W =
    ($clog2(NUM_PRIOS + 2) > PRIO_W) ? $clog2(NUM_PRIOS + 2) : PRIO_W;

  logic [NUM_PRIOS-1:0] ready_bits, ready_bits_next;
  logic [CEIL_W-1:0]    ceiling_now, ceiling_now_next;
  logic [PRIO_W-1:0]    active_threshold, active_threshold_next;

  logic [NUM_PRIOS-1:0] prio_mask;
  logic [NUM_PRIOS-1:0] ready_pick;
  logic [CEIL_W-1:0]    highest;
  logic [CEIL_W-1:0]    tp_w, lv_w;
  logic [CEIL_W-1:0]    pick_ceil;
  logic [PRIO_W-1:0]    pick_thr;
  logic [CEIL_W-1:0]    picked;
  op_t                  op;

  assign op   = op_t'(item.opcode);
  assign tp_w = CEIL_W'(item.task_prio);
  assign lv_w = CEIL_W'(item.level);

  // one-hot of task_prio; zero when out of range
  always_comb begin
    for (int i = 0; i < NUM_PRIOS; i++) begin
      prio_mask[i] = (tp_w == CEIL_W'(i + 1));
    end
  end

  // after_dispatch with queue_empty clears the task's bit before rescheduling
  assign ready_pick = (op == OP_AFTER_DISPATCH && item.queue_empty) ?
                      (ready_bits & ~prio_mask) : ready_bits;

  always_comb begin
    highest = '0;
    for (int i = 0; i < NUM_PRIOS; i++) begin
      if (ready_pick[i]) highest = CEIL_W'(i + 1);
    end
  end

  // unlock schedules against the restored ceiling
  assign pick_ceil = (op == OP_UNLOCK) ? lv_w : ceiling_now;
  assign pick_thr  = (op == OP_AFTER_DISPATCH) ? item.level : active_threshold;
  assign picked    = (highest != '0 && highest > CEIL_W'(pick_thr) &&
                      highest > pick_ceil) ? highest : '0;

  always_comb begin
    ready_bits_next       = ready_bits;
    ceiling_now_next      = ceiling_now;
    active_threshold_next = active_threshold;
    res                   = '0;
    case (op)
      OP_MARK_READY: begin
        ready_bits_next = ready_bits | prio_mask;
      end
      OP_LOCK: begin
        if (lv_w > ceiling_now) begin
          res.ceil_before  = ceiling_now[PRIO_W-1:0];
          ceiling_now_next = lv_w;
        end else begin
          res.not_locked = 1'b1;
        end
      end
      OP_UNLOCK: begin
        if (!item.prev_not_locked) begin
          if (ceiling_now > lv_w) begin
            ceiling_now_next = lv_w;
            res.run_prio     = picked[PRIO_W-1:0];
          end else begin
            res.error = 1'b1;
          end
        end
      end
      OP_SCHEDULE: begin
        res.run_prio = picked[PRIO_W-1:0];
      end
      OP_AFTER_DISPATCH: begin
        ready_bits_next = ready_pick;
        res.run_prio    = picked[PRIO_W-1:0];
      end
      OP_SET_ACTIVE: begin
        active_threshold_next = item.level;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_bits       <= '0;
      ceiling_now      <= CEIL_W'(NUM_PRIOS + 1);
      active_threshold <= '0;
    end else if (en) begin
      ready_bits       <= ready_bits_next;
      ceiling_now      <= ceiling_now_next;
      active_threshold <= active_threshold_next;
    end
  end

endmodule
`default_nettype wire
